// ===== hw/rtl/assert_macros.svh =====
// assertion macros included by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, switched off while reset is held
`define AEC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("aec assertion failed");
// clocked check that also holds through reset
`define AEC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("aec assertion failed");
`else
`define AEC_ASSERT(lbl, clk, rst_n, prop)
`define AEC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== hw/rtl/aec_pkg.sv =====
// types and constants of the embedded controller host interface
package aec_pkg;

    localparam logic [7:0] CMD_READ  = 8'h80;
    localparam logic [7:0] CMD_WRITE = 8'h81;
    localparam logic [7:0] CMD_QUERY = 8'h84;

    localparam logic [7:0] STAT_OBF = 8'h01;
    localparam logic [7:0] STAT_IBF = 8'h02;
    localparam logic [7:0] STAT_SCI = 8'h20;

    localparam logic PORT_DATA = 1'b0;
    localparam logic PORT_CMD  = 1'b1;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_EVENT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_RD_ADDR = 2'd1,
        PH_WR_ADDR = 2'd2,
        PH_WR_DATA = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        OUT_OK      = 2'd0,
        OUT_STRAY   = 2'd1,
        OUT_UNKNOWN = 2'd2,
        OUT_DROPPED = 2'd3
    } t_outcome;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] held_addr;
        logic [7:0] out_buf;
        logic       out_full;
        logic [7:0] pend;
    } t_state;

    typedef struct packed {
        logic [7:0] rd_data;
        logic       obf;
        logic       sci;
        t_outcome   outcome;
    } t_result;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } t_memwr;

endpackage

// ===== hw/rtl/aec_mem.sv =====
// ec space byte ram with per-entry valid bits and registered read
module aec_mem
    import aec_pkg::*;
#(
    parameter int SPACE_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rd_en,
    input  logic [7:0] i_rd_addr,
    input  t_memwr     i_wr,
    output logic [7:0] o_rd_data
);

    localparam int AW = $clog2(SPACE_DEPTH);

    // byte address folded into the ram by repeated subtraction, four steps
    function automatic logic [AW-1:0] f_index(input logic [7:0] a);
        logic [11:0] v;
        v = {4'd0, a};
        for (int k = 3; k >= 0; k--) begin
            if (v >= 12'(SPACE_DEPTH << k)) begin
                v = v - 12'(SPACE_DEPTH << k);
            end
        end
        return v[AW-1:0];
    endfunction

    logic [7:0]             r_mem [SPACE_DEPTH];
    logic [SPACE_DEPTH-1:0] r_vld;
    logic [7:0]             r_rdata;
    logic                   r_rvld;
    logic [AW-1:0]          w_ridx;
    logic [AW-1:0]          w_widx;

    assign w_ridx = f_index(i_rd_addr);
    assign w_widx = f_index(i_wr.addr);

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[w_widx] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[w_widx] <= 1'b1;
        end
    end

    // a write in the same cycle bypasses the array
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr.en && (w_widx == w_ridx)) begin
                r_rdata <= i_wr.data;
                r_rvld  <= 1'b1;
            end else begin
                r_rdata <= r_mem[w_ridx];
                r_rvld  <= r_vld[w_ridx];
            end
        end
    end

    assign o_rd_data = r_rvld ? r_rdata : 8'h00;

endmodule

// ===== hw/rtl/aec_core.sv =====
// port decode and next-state logic for one host access or event
module aec_core
    import aec_pkg::*;
(
    input  logic [1:0] i_command,
    input  logic       i_port_sel,
    input  logic [7:0] i_wr_data,
    input  logic [7:0] i_event_code,
    input  t_state     i_st,
    input  logic [7:0] i_ram_data,
    output t_state     o_st,
    output t_result    o_res,
    output t_memwr     o_wr
);

    t_state     n_st;
    t_outcome   w_outcome;
    logic [7:0] w_rd;

    always_comb begin
        n_st      = i_st;
        w_outcome = OUT_OK;
        w_rd      = 8'h00;
        o_wr.en   = 1'b0;
        o_wr.addr = i_st.held_addr;
        o_wr.data = i_wr_data;
        case (i_command)
            KIND_WRITE: begin
                if (i_port_sel == PORT_CMD) begin
                    case (i_wr_data)
                        CMD_READ:  n_st.phase = PH_RD_ADDR;
                        CMD_WRITE: n_st.phase = PH_WR_ADDR;
                        CMD_QUERY: begin
                            n_st.out_buf  = i_st.pend;
                            n_st.out_full = 1'b1;
                            n_st.pend     = 8'h00;
                            n_st.phase    = PH_IDLE;
                        end
                        default:   w_outcome = OUT_UNKNOWN;
                    endcase
                end else begin
                    case (i_st.phase)
                        PH_RD_ADDR: begin
                            n_st.out_buf  = i_ram_data;
                            n_st.out_full = 1'b1;
                            n_st.phase    = PH_IDLE;
                        end
                        PH_WR_ADDR: begin
                            n_st.held_addr = i_wr_data;
                            n_st.phase     = PH_WR_DATA;
                        end
                        PH_WR_DATA: begin
                            o_wr.en    = 1'b1;
                            n_st.phase = PH_IDLE;
                        end
                        default:    w_outcome = OUT_STRAY;
                    endcase
                end
            end
            KIND_READ: begin
                if (i_port_sel == PORT_CMD) begin
                    // ibf never set: every write is consumed at once
                    w_rd = (i_st.out_full ? STAT_OBF : 8'h00)
                         | ((i_st.pend != 8'h00) ? STAT_SCI : 8'h00);
                end else begin
                    w_rd          = i_st.out_buf;
                    n_st.out_full = 1'b0;
                end
            end
            KIND_EVENT: begin
                if ((i_st.pend != 8'h00) || (i_event_code == 8'h00)) begin
                    w_outcome = OUT_DROPPED;
                end else begin
                    n_st.pend = i_event_code;
                end
            end
            default: w_outcome = OUT_UNKNOWN;
        endcase
    end

    assign o_st          = n_st;
    assign o_res.rd_data = w_rd;
    assign o_res.obf     = n_st.out_full;
    assign o_res.sci     = (n_st.pend != 8'h00);
    assign o_res.outcome = w_outcome;

endmodule

// ===== hw/rtl/acpi_ec_host_interface.sv =====
// embedded controller host interface top level: input stage, decode, result register
//
//  channel | direction | handshake                | word
//  --------+-----------+--------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_ready  | i_command, i_port_sel, i_wr_data,
//          |           |                          | i_event_code
//  out     | output    | o_out_valid / i_out_ready| o_rd_data, o_obf_flag, o_sci_flag,
//          |           |                          | o_outcome
//
// one word per cycle unless output stalls; stages: input stage, then result register
// the ram is read at the input edge with the raw byte, a write in flight is bypassed
// reset (synchronous, i_rst_n low) clears the phase, flags, query and ram valid bits
// a stalled result holds the decode stage; the input stays open while that stage moves
`include "assert_macros.svh"

module acpi_ec_host_interface
    import aec_pkg::*;
#(
    parameter int SPACE_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_command,
    input  logic       i_port_sel,
    input  logic [7:0] i_wr_data,
    input  logic [7:0] i_event_code,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_rd_data,
    output logic       o_obf_flag,
    output logic       o_sci_flag,
    output logic [1:0] o_outcome
);

    logic       r_s1_vld;
    logic [1:0] r_command;
    logic       r_port_sel;
    logic [7:0] r_wr_data;
    logic [7:0] r_event_code;
    t_state     r_st;
    logic       r_out_vld;
    t_result    r_out;

    logic       w_accept;
    logic       w_adv;
    logic [7:0] w_ram;
    t_state     n_st;
    t_result    n_out;
    t_memwr     w_wr;
    t_memwr     w_wr_gated;

    assign w_adv      = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || w_adv;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_wr_gated.en   = w_wr.en && w_adv;
    assign w_wr_gated.addr = w_wr.addr;
    assign w_wr_gated.data = w_wr.data;

    aec_mem #(
        .SPACE_DEPTH(SPACE_DEPTH)
    ) u_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (w_accept),
        .i_rd_addr(i_wr_data),
        .i_wr     (w_wr_gated),
        .o_rd_data(w_ram)
    );

    aec_core u_core (
        .i_command   (r_command),
        .i_port_sel  (r_port_sel),
        .i_wr_data   (r_wr_data),
        .i_event_code(r_event_code),
        .i_st        (r_st),
        .i_ram_data  (w_ram),
        .o_st        (n_st),
        .o_res       (n_out),
        .o_wr        (w_wr)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_command    <= i_command;
            r_port_sel   <= i_port_sel;
            r_wr_data    <= i_wr_data;
            r_event_code <= i_event_code;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld       <= 1'b0;
            r_out_vld      <= 1'b0;
            r_st.phase     <= PH_IDLE;
            r_st.held_addr <= 8'h00;
            r_st.out_buf   <= 8'h00;
            r_st.out_full  <= 1'b0;
            r_st.pend      <= 8'h00;
        end else begin
            if (w_accept) begin
                r_s1_vld <= 1'b1;
            end else if (w_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
                r_st      <= n_st;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_rd_data   = r_out.rd_data;
    assign o_obf_flag  = r_out.obf;
    assign o_sci_flag  = r_out.sci;
    assign o_outcome   = r_out.outcome;

    `AEC_ASSERT(a_ready_only_when_held, i_clk, i_rst_n, !o_in_ready |-> r_s1_vld)
    `AEC_ASSERT(a_accept_fills_stage, i_clk, i_rst_n, w_accept |=> r_s1_vld)
    `AEC_ASSERT(a_adv_fills_output, i_clk, i_rst_n, w_adv |=> r_out_vld)
    `AEC_ASSERT(a_flags_match_state, i_clk, i_rst_n, r_out_vld |-> ((o_obf_flag == r_st.out_full) && (o_sci_flag == (r_st.pend != 8'h00))))
    `AEC_ASSERT_ALWAYS(a_no_write_when_idle, i_clk, w_wr_gated.en |-> r_s1_vld)

endmodule

// ===== dv/tb_acpi_ec_host_interface.sv =====
// self-checking testbench for the embedded controller host interface
`timescale 1ns / 100ps

module tb_acpi_ec_host_interface;
    import aec_pkg::*;

    localparam int SPACE_DEPTH   = 256;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 80;
    localparam int RANDOM_WORDS  = 1950;

    typedef struct packed {
        logic [1:0] command;
        logic       port_sel;
        logic [7:0] wr_data;
        logic [7:0] event_code;
    } t_host_word;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [1:0] i_command    = 2'd0;
    logic       i_port_sel   = 1'b0;
    logic [7:0] i_wr_data    = 8'd0;
    logic [7:0] i_event_code = 8'd0;
    logic       i_out_ready  = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_rd_data;
    logic       o_obf_flag;
    logic       o_sci_flag;
    logic [1:0] o_outcome;

    acpi_ec_host_interface #(
        .SPACE_DEPTH(SPACE_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_port_sel  (i_port_sel),
        .i_wr_data   (i_wr_data),
        .i_event_code(i_event_code),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_rd_data   (o_rd_data),
        .o_obf_flag  (o_obf_flag),
        .o_sci_flag  (o_sci_flag),
        .o_outcome   (o_outcome)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // host-visible copy of the controller state
    logic [7:0] ram_copy [SPACE_DEPTH];
    t_phase     cur_phase    = PH_IDLE;
    logic [7:0] latched_addr = 8'd0;
    logic [7:0] obuf         = 8'd0;
    logic       obuf_full    = 1'b0;
    logic [7:0] query_code   = 8'd0;

    t_host_word word_queue [$];
    t_result    awaited_results [$];
    int         total_words = 0;
    int         words_in    = 0;
    int         error_count = 0;
    logic       word_taken  = 1'b0;

    logic [7:0] addr_pool [8] = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h0F, 8'hF0, 8'h80, 8'h7F};

    function automatic t_result host_access(input t_host_word w);
        t_result r;
        r = '0;
        r.outcome = OUT_OK;
        case (w.command)
            KIND_WRITE: begin
                if (w.port_sel == PORT_CMD) begin
                    if (w.wr_data == CMD_READ) begin
                        cur_phase = PH_RD_ADDR;
                    end else if (w.wr_data == CMD_WRITE) begin
                        cur_phase = PH_WR_ADDR;
                    end else if (w.wr_data == CMD_QUERY) begin
                        obuf = query_code;
                        obuf_full = 1'b1;
                        query_code = 8'd0;
                        cur_phase = PH_IDLE;
                    end else begin
                        r.outcome = OUT_UNKNOWN;
                    end
                end else begin
                    case (cur_phase)
                        PH_RD_ADDR: begin
                            obuf = ram_copy[w.wr_data % SPACE_DEPTH];
                            obuf_full = 1'b1;
                            cur_phase = PH_IDLE;
                        end
                        PH_WR_ADDR: begin
                            latched_addr = w.wr_data;
                            cur_phase = PH_WR_DATA;
                        end
                        PH_WR_DATA: begin
                            ram_copy[latched_addr % SPACE_DEPTH] = w.wr_data;
                            cur_phase = PH_IDLE;
                        end
                        default: r.outcome = OUT_STRAY;
                    endcase
                end
            end
            KIND_READ: begin
                if (w.port_sel == PORT_CMD) begin
                    r.rd_data = (obuf_full ? STAT_OBF : 8'h00)
                              | (query_code != 8'd0 ? STAT_SCI : 8'h00);
                end else begin
                    obuf_full = 1'b0;
                    r.rd_data = obuf;
                end
            end
            KIND_EVENT: begin
                if (query_code != 8'd0 || w.event_code == 8'd0) begin
                    r.outcome = OUT_DROPPED;
                end else begin
                    query_code = w.event_code;
                end
            end
            default: r.outcome = OUT_UNKNOWN;
        endcase
        r.obf = obuf_full;
        r.sci = (query_code != 8'd0);
        return r;
    endfunction

    task automatic push_word(input logic [1:0] c, input logic p, input logic [7:0] d,
                             input logic [7:0] e);
        t_host_word w;
        w.command = c;
        w.port_sel = p;
        w.wr_data = d;
        w.event_code = e;
        word_queue.push_back(w);
    endtask

    task automatic check_field(input string fname, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %02h actual %02h", $realtime, fname, want, got);
            error_count++;
        end
    endtask

    // 0: sender 25 / receiver 59, 1: swapped, 2: no idling
    function automatic int idle_mode();
        if (words_in < total_words / 3)
            return 0;
        if (words_in < (2 * total_words) / 3)
            return 1;
        return 2;
    endfunction

    function automatic logic [7:0] pick_addr();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom);
        return addr_pool[$urandom_range(0, 7)];
    endfunction

    // sender
    always @(negedge i_clk) begin
        t_host_word w;
        int pct;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || word_taken) begin
            pct = (idle_mode() == 0) ? 25 : (idle_mode() == 1) ? 59 : 0;
            if (word_queue.size() > 0 && $urandom_range(0, 99) >= pct) begin
                w = word_queue.pop_front();
                i_command    <= w.command;
                i_port_sel   <= w.port_sel;
                i_wr_data    <= w.wr_data;
                i_event_code <= w.event_code;
                i_in_valid   <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver, with a long hold-off now and then so the block backs up
    int hold_left    = 0;
    int next_hold_at = 500;
    always @(negedge i_clk) begin
        int pct;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (words_in >= next_hold_at) begin
            hold_left = HOLD_CYCLES;
            next_hold_at = next_hold_at + 1000;
            i_out_ready <= 1'b0;
        end else begin
            pct = (idle_mode() == 0) ? 59 : (idle_mode() == 1) ? 25 : 0;
            i_out_ready <= ($urandom_range(0, 99) >= pct);
        end
    end

    // predict on each taken word, check each delivered result
    always @(posedge i_clk) begin
        t_host_word w;
        t_result want;
        if (i_rst_n) begin
            word_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                w.command = i_command;
                w.port_sel = i_port_sel;
                w.wr_data = i_wr_data;
                w.event_code = i_event_code;
                awaited_results.push_back(host_access(w));
                words_in++;
            end
            if (o_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %02h/%b/%b/%0d",
                             $realtime, o_rd_data, o_obf_flag, o_sci_flag, o_outcome);
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("rd_data", want.rd_data, o_rd_data);
                    check_field("obf_flag", 8'(want.obf), 8'(o_obf_flag));
                    check_field("sci_flag", 8'(want.sci), 8'(o_sci_flag));
                    check_field("outcome", 8'(want.outcome), 8'(o_outcome));
                end
            end
        end
    end

    int stall_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stall_cycles = 0;
            else
                stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("tb_acpi_ec_host_interface: errors");
                $finish;
            end
        end
    end

    initial begin
        int sel;
        int target;
        logic [7:0] a;
        for (int i = 0; i < SPACE_DEPTH; i++)
            ram_copy[i] = 8'd0;

        // directed: empty status, stale read, stray data, ram extremes
        push_word(KIND_READ,  PORT_CMD,  8'h00, 8'h00);
        push_word(KIND_READ,  PORT_DATA, 8'hFF, 8'hFF);
        push_word(KIND_WRITE, PORT_DATA, 8'hFF, 8'h00);
        push_word(KIND_WRITE, PORT_CMD,  CMD_WRITE, 8'h00);
        push_word(KIND_WRITE, PORT_DATA, 8'hFF, 8'h00);
        push_word(KIND_WRITE, PORT_DATA, 8'hA5, 8'h00);
        push_word(KIND_WRITE, PORT_CMD,  CMD_READ, 8'h00);
        push_word(KIND_WRITE, PORT_DATA, 8'hFF, 8'h00);
        push_word(KIND_READ,  PORT_CMD,  8'h00, 8'h00);
        // buffer overwritten while still full, then read twice
        push_word(KIND_WRITE, PORT_CMD,  CMD_READ, 8'h00);
        push_word(KIND_WRITE, PORT_DATA, 8'h00, 8'h00);
        push_word(KIND_READ,  PORT_DATA, 8'h00, 8'h00);
        push_word(KIND_READ,  PORT_DATA, 8'h00, 8'h00);
        // unknown command bytes, burst codes included
        push_word(KIND_WRITE, PORT_CMD,  8'h82, 8'h00);
        push_word(KIND_WRITE, PORT_CMD,  8'h83, 8'h00);
        push_word(KIND_WRITE, PORT_CMD,  8'hFF, 8'h00);
        // events: zero code, max code, second while pending, then query twice
        push_word(KIND_EVENT, PORT_DATA, 8'h00, 8'h00);
        push_word(KIND_EVENT, PORT_CMD,  8'h00, 8'hFF);
        push_word(KIND_EVENT, PORT_DATA, 8'h00, 8'h01);
        push_word(KIND_READ,  PORT_CMD,  8'h00, 8'h00);
        push_word(KIND_WRITE, PORT_CMD,  CMD_QUERY, 8'h00);
        push_word(KIND_READ,  PORT_DATA, 8'h00, 8'h00);
        push_word(KIND_WRITE, PORT_CMD,  CMD_QUERY, 8'h00);
        // step kind 3, then a write sequence cut short by a read command
        push_word(2'd3,       PORT_CMD,  8'hFF, 8'hFF);
        push_word(KIND_WRITE, PORT_CMD,  CMD_WRITE, 8'h00);
        push_word(KIND_WRITE, PORT_CMD,  CMD_READ, 8'h00);
        push_word(KIND_WRITE, PORT_DATA, 8'hFF, 8'h00);

        target = word_queue.size() + RANDOM_WORDS;
        while (word_queue.size() < target) begin
            sel = $urandom_range(0, 99);
            a = pick_addr();
            if (sel < 30) begin
                push_word(KIND_WRITE, PORT_CMD,  CMD_WRITE, 8'($urandom));
                push_word(KIND_WRITE, PORT_DATA, a, 8'($urandom));
                push_word(KIND_WRITE, PORT_DATA, 8'($urandom), 8'($urandom));
            end else if (sel < 55) begin
                push_word(KIND_WRITE, PORT_CMD,  CMD_READ, 8'($urandom));
                push_word(KIND_WRITE, PORT_DATA, a, 8'($urandom));
                if ($urandom_range(0, 3) == 0)
                    push_word(KIND_READ, PORT_CMD, 8'($urandom), 8'($urandom));
                push_word(KIND_READ,  PORT_DATA, 8'($urandom), 8'($urandom));
            end else if (sel < 70) begin
                push_word(KIND_EVENT, 1'($urandom), 8'($urandom),
                          ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
                if ($urandom_range(0, 1) == 0)
                    push_word(KIND_READ, PORT_CMD, 8'($urandom), 8'($urandom));
                push_word(KIND_WRITE, PORT_CMD,  CMD_QUERY, 8'($urandom));
                push_word(KIND_READ,  PORT_DATA, 8'($urandom), 8'($urandom));
            end else if (sel < 78) begin
                push_word(KIND_READ, PORT_CMD, 8'($urandom), 8'($urandom));
            end else if (sel < 86) begin
                // sequence abandoned part way by another command
                push_word(KIND_WRITE, PORT_CMD, ($urandom_range(0, 1) == 0) ? CMD_WRITE : CMD_READ,
                          8'($urandom));
                if ($urandom_range(0, 1) == 0)
                    push_word(KIND_WRITE, PORT_DATA, a, 8'($urandom));
                push_word(KIND_WRITE, PORT_CMD,
                          ($urandom_range(0, 2) == 0) ? CMD_QUERY :
                          ($urandom_range(0, 1) == 0) ? CMD_READ : CMD_WRITE, 8'($urandom));
            end else begin
                push_word(2'($urandom_range(0, 3)), 1'($urandom), 8'($urandom), 8'($urandom));
            end
        end
        total_words = word_queue.size();

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (word_queue.size() != 0 || i_in_valid || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (awaited_results.size() != 0) begin
            $display("%0t: results missing, expected %0d actual 0", $realtime,
                     awaited_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("tb_acpi_ec_host_interface: clean");
        end else begin
            $display("tb_acpi_ec_host_interface: errors");
        end
        $finish;
    end

endmodule
